// ----- hw/rtl/crc8_checked_frame_receiver_assert.svh -----
// assertion macros shared by the receiver modules
`ifndef CRC8_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define CRC8_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define CRC8FR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("crc8fr assertion failed");
// condition must never be true outside reset
`define CRC8FR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("crc8fr forbidden condition seen");
`else
`define CRC8FR_ASSERT(lbl, prop)
`define CRC8FR_NEVER(lbl, cond)
`endif
`endif

// ----- hw/rtl/crc8fr_pkg.sv -----
`default_nettype none
package crc8fr_pkg;

  localparam int WORD_COUNT = 10;
  localparam int OUT_WORDS  = 10;
  localparam int WORD_W     = 32;
  localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] HDR0_RST  = 8'h55;
  localparam logic [7:0] HDR1_RST  = 8'hAA;

  localparam logic [5:0] POS_HDR0      = 6'd0;
  localparam logic [5:0] POS_HDR1      = 6'd1;
  localparam logic [5:0] POS_WORD0     = 6'd3;
  localparam logic [5:0] CRC_SPAN      = 6'd42;
  localparam logic [5:0] CRC_POS       = 6'd43;
  localparam logic [5:0] LAST_KEPT     = 6'd45;
  localparam logic [5:0] POS_MAX       = 6'd63;

  localparam logic CFG_HEADER_FIRST  = 1'b0;
  localparam logic CFG_HEADER_SECOND = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_HDR   = 2'd1,
    ST_SHORT = 2'd2,
    ST_CRC   = 2'd3
  } status_t;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [OUT_WORDS-1:0] word_arr_t;

  // one classified byte travelling from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic       frame_end;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } hdr_cfg_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/crc8fr_front.sv -----
`default_nettype none
`include "crc8_checked_frame_receiver_assert.svh"
module crc8fr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  output logic                  q_push,
  output crc8fr_pkg::q_entry_t  q_wr,
  input  logic                  q_full
);
  import crc8fr_pkg::*;

  logic [5:0] pos_r, pos_nxt;
  logic       last_cr_r, last_cr_nxt;
  logic       frame_end;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;
  assign frame_end = last_cr_r && (in_rx_byte == CHAR_LF);

  assign q_wr.data      = in_rx_byte;
  assign q_wr.pos       = pos_r;
  assign q_wr.frame_end = frame_end;

  always_comb begin
    pos_nxt     = pos_r;
    last_cr_nxt = last_cr_r;
    if (q_push) begin
      if (frame_end) begin
        pos_nxt     = '0;
        last_cr_nxt = 1'b0;
      end else begin
        last_cr_nxt = (in_rx_byte == CHAR_CR);
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      last_cr_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      last_cr_r <= last_cr_nxt;
    end
  end

  `CRC8FR_ASSERT(a_front_end_clears_pos, (q_push && frame_end) |=> (pos_r == '0 && !last_cr_r))

endmodule
`default_nettype wire

// ----- hw/rtl/crc8fr_queue.sv -----
`default_nettype none
`include "crc8_checked_frame_receiver_assert.svh"
module crc8fr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  crc8fr_pkg::q_entry_t  wr,
  output logic                  full,
  input  logic                  pop,
  output crc8fr_pkg::q_entry_t  head,
  output logic                  head_valid
);
  import crc8fr_pkg::*;

  q_entry_t             entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + Q_CNT_W'(1);
      2'b01:   count_nxt = count_r - Q_CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr;
    end
  end

  `CRC8FR_NEVER(a_queue_overfill, count_r > Q_CNT_W'(Q_DEPTH))
  `CRC8FR_NEVER(a_queue_pop_empty, pop && !head_valid)

endmodule
`default_nettype wire

// ----- hw/rtl/crc8fr_back.sv -----
`default_nettype none
`include "crc8_checked_frame_receiver_assert.svh"
module crc8fr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crc8fr_pkg::q_entry_t  q_head,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  crc8fr_pkg::hdr_cfg_t  hdr,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output crc8fr_pkg::word_arr_t out_words
);
  import crc8fr_pkg::*;

  localparam logic [3:0] WORD_LIM = 4'(WORD_COUNT);

  word_t       payload_r [WORD_COUNT];
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  rcv_r, rcv_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, status_c;
  word_arr_t   out_words_r, words_c;

  logic        kept;
  logic [5:0]  off;
  logic [3:0]  widx_full;
  logic [1:0]  lane;
  logic        store_en;
  logic        emit;

  // back end stalls only when a frame end meets a full output register
  assign q_pop = q_valid && (!q_head.frame_end || !out_valid_r || out_ready);
  assign emit  = q_pop && q_head.frame_end;

  assign kept      = (q_head.pos <= LAST_KEPT);
  assign off       = q_head.pos - POS_WORD0;
  assign widx_full = off[5:2];
  assign lane      = off[1:0];
  assign store_en  = kept && (q_head.pos >= POS_WORD0) && (widx_full < WORD_LIM);

  always_comb begin
    hdr_good_nxt = hdr_good_r;
    crc_nxt      = crc_r;
    rcv_nxt      = rcv_r;
    if (kept) begin
      if (q_head.pos == POS_HDR0 && q_head.data != hdr.first)  hdr_good_nxt = 1'b0;
      if (q_head.pos == POS_HDR1 && q_head.data != hdr.second) hdr_good_nxt = 1'b0;
      if (q_head.pos < CRC_SPAN) crc_nxt = crc8_byte(crc_r, q_head.data);
      if (q_head.pos == CRC_POS) rcv_nxt = q_head.data;
    end
  end

  always_comb begin
    if (!hdr_good_nxt) begin
      status_c = ST_HDR;
    end else if (q_head.pos < LAST_KEPT) begin
      status_c = ST_SHORT;
    end else if (crc_nxt != rcv_nxt) begin
      status_c = ST_CRC;
    end else begin
      status_c = ST_OK;
    end
  end

  for (genvar k = 0; k < OUT_WORDS; k++) begin : g_words
    if (k < WORD_COUNT) begin : g_used
      assign words_c[k] = (status_c == ST_OK) ? payload_r[k] : '0;
    end else begin : g_unused
      assign words_c[k] = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      rcv_r       <= '0;
      hdr_good_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        crc_r      <= '0;
        rcv_r      <= '0;
        hdr_good_r <= 1'b1;
      end else if (q_pop) begin
        crc_r      <= crc_nxt;
        rcv_r      <= rcv_nxt;
        hdr_good_r <= hdr_good_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= status_c;
      out_words_r  <= words_c;
    end
    if (q_pop && store_en) begin
      payload_r[widx_full[WIDX_W-1:0]][lane*8 +: 8] <= q_head.data;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_words  = out_words_r;

  `CRC8FR_ASSERT(a_back_err_words_zero, (out_valid_r && out_status_r != ST_OK) |-> (out_words_r == '0))
  `CRC8FR_NEVER(a_back_no_overwrite, emit && out_valid_r && !out_ready)

endmodule
`default_nettype wire

// ----- hw/rtl/crc8_checked_frame_receiver.sv -----
// result path: a frame's accepted closing lf byte is written into the byte queue, popped by
// the back end once every byte queued ahead of it has gone, and then sets the registered out_valid
// throughput: one byte per cycle while the byte queue has room; the back end holds only when
// a frame end meets a result waiting on out_ready, and the front once the four-entry queue fills
// reset: synchronous, active low rst_n; clears frame state, queue and output valid,
// and loads the header registers with 0x55 and 0xaa; stored payload words are not cleared
`default_nettype none
module crc8_checked_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // frame results out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  output logic [31:0] out_word2,
  output logic [31:0] out_word3,
  output logic [31:0] out_word4,
  output logic [31:0] out_word5,
  output logic [31:0] out_word6,
  output logic [31:0] out_word7,
  output logic [31:0] out_word8,
  output logic [31:0] out_word9,
  // header register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import crc8fr_pkg::*;

  hdr_cfg_t   hdr_r;
  q_entry_t   q_wr, q_head;
  logic       q_push, q_full, q_pop, q_valid;
  word_arr_t  words;

  // register port never stalls; the user must write only while the block is idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r.first  <= HDR0_RST;
      hdr_r.second <= HDR1_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER_FIRST:  hdr_r.first  <= cfg_data;
        CFG_HEADER_SECOND: hdr_r.second <= cfg_data;
        default:           hdr_r        <= hdr_r;
      endcase
    end
  end

  // front: counts frame position and spots the cr lf terminator
  crc8fr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_push     (q_push),
    .q_wr       (q_wr),
    .q_full     (q_full)
  );

  // short queue so the front keeps taking bytes while a result waits
  crc8fr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wr         (q_wr),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  // back: header check, crc-8, payload capture and the result register
  crc8fr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .hdr        (hdr_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_words  (words)
  );

  assign out_word0 = words[0];
  assign out_word1 = words[1];
  assign out_word2 = words[2];
  assign out_word3 = words[3];
  assign out_word4 = words[4];
  assign out_word5 = words[5];
  assign out_word6 = words[6];
  assign out_word7 = words[7];
  assign out_word8 = words[8];
  assign out_word9 = words[9];

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crc8fr_pkg::*;

  // run limits and pacing
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off to back the queue up
  localparam int DRAIN_CYCLES = 8;     // bytes may still sit in the queue after the last result
  localparam int RANDOM_BYTES = 850;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t   status;
    word_arr_t words;
  } frame_result_t;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_HDR,
    FR_LONG,
    FR_SHORT,
    FR_NOISE
  } frame_kind_t;

  // frame predictor plus the store of frame results still owed by the block
  class frame_scoreboard;
    logic [7:0]    hdr_first;
    logic [7:0]    hdr_second;
    logic [5:0]    pos;
    logic [7:0]    crc_acc;
    logic [7:0]    crc_rx;
    bit            hdr_ok;
    bit            saw_cr;
    word_arr_t     words;
    frame_result_t expected_q[$];
    int            errors;
    int            frames_seen;
    int            frames_predicted;

    function new();
      hdr_first        = HDR0_RST;
      hdr_second       = HDR1_RST;
      words            = '0;
      errors           = 0;
      frames_seen      = 0;
      frames_predicted = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos     = '0;
      crc_acc = '0;
      crc_rx  = '0;
      hdr_ok  = 1'b1;
      saw_cr  = 1'b0;
    endfunction

    function void set_header(logic idx, logic [7:0] val);
      if (idx == CFG_HEADER_FIRST) hdr_first = val;
      else hdr_second = val;
    endfunction

    // reflected crc-8, data fed lsb first through the shift register
    function logic [7:0] crc_update(logic [7:0] acc, logic [7:0] d);
      logic [7:0] r;
      logic       fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ d[i];
        r  = {1'b0, r[7:1]};
        if (fb) r = r ^ CRC_POLY;
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      frame_result_t r;
      int            off;
      if (pos <= LAST_KEPT) begin
        if (pos == POS_HDR0 && b != hdr_first) hdr_ok = 1'b0;
        if (pos == POS_HDR1 && b != hdr_second) hdr_ok = 1'b0;
        if (pos < CRC_SPAN) crc_acc = crc_update(crc_acc, b);
        if (pos == CRC_POS) crc_rx = b;
        if (pos >= POS_WORD0) begin
          off = int'(pos - POS_WORD0);
          if (off / 4 < WORD_COUNT) words[off / 4][8 * (off % 4) +: 8] = b;
        end
      end
      if (saw_cr && b == CHAR_LF) begin
        // header beats short, short beats checksum
        if (!hdr_ok) r.status = ST_HDR;
        else if (pos < LAST_KEPT) r.status = ST_SHORT;
        else if (crc_acc != crc_rx) r.status = ST_CRC;
        else r.status = ST_OK;
        r.words = (r.status == ST_OK) ? words : '0;
        expected_q.push_back(r);
        frames_predicted++;
        clear_frame();
      end else begin
        saw_cr = (b == CHAR_CR);
        if (pos != POS_MAX) pos = pos + 6'd1;
      end
    endfunction

    function void flag(string field, logic [31:0] exp_v, logic [31:0] act_v);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("frame %0d %s: expected %h, got %h", frames_seen, field, exp_v, act_v);
    endfunction

    function void check_frame(logic [1:0] st, word_arr_t w);
      frame_result_t r;
      frames_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("frame %0d arrived with nothing pending, status %0d", frames_seen, st);
        return;
      end
      r = expected_q.pop_front();
      if (st !== r.status) flag("status", r.status, st);
      for (int k = 0; k < OUT_WORDS; k++)
        if (w[k] !== r.words[k]) flag($sformatf("word%0d", k), r.words[k], w[k]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // dut ports; the dut inputs are all driven to known values from time zero
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_word0, out_word1, out_word2, out_word3, out_word4;
  logic [31:0] out_word5, out_word6, out_word7, out_word8, out_word9;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = CFG_HEADER_FIRST;
  logic [7:0]  cfg_data   = 8'h00;

  crc8_checked_frame_receiver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_word0  (out_word0),
    .out_word1  (out_word1),
    .out_word2  (out_word2),
    .out_word3  (out_word3),
    .out_word4  (out_word4),
    .out_word5  (out_word5),
    .out_word6  (out_word6),
    .out_word7  (out_word7),
    .out_word8  (out_word8),
    .out_word9  (out_word9),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  frame_scoreboard sb = new();

  // stimulus-side view of the header registers
  logic [7:0] hdr_now_first  = HDR0_RST;
  logic [7:0] hdr_now_second = HDR1_RST;

  // pacing state shared by the sender and the receiver
  int tx_mode         = 0;
  int rx_mode         = 0;
  int hold_off_cycles = 0;
  bit burst_active    = 1'b0;
  int bytes_sent      = 0;
  int cycle_count     = 0;

  // mode 0 never idles, mode 1 idles freely, mode 2 idles now and then
  function automatic int draw_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 14);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  function automatic logic [7:0] content_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // noise leans on cr and lf so that stray frame ends turn up
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    return 8'($urandom);
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return FR_GOOD;
    if (r < 60) return FR_BAD_CRC;
    if (r < 68) return FR_BAD_HDR;
    if (r < 80) return FR_LONG;
    if (r < 92) return FR_SHORT;
    return FR_NOISE;
  endfunction

  // one byte transaction, entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst_active ? 0 : draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_byte(b);
    bytes_sent++;
    // reshuffle idling on both sides every so often
    if (bytes_sent % 40 == 0) begin
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
    end
    @(negedge clk);
  endtask

  // stop sending and let every owed frame come out, plus bytes still queued
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.set_header(idx, val);
    @(negedge clk);
  endtask

  // header registers only change with the block idle and no frame open
  task automatic set_headers(input logic [7:0] first, input logic [7:0] second);
    drain_results();
    write_reg(CFG_HEADER_FIRST, first);
    write_reg(CFG_HEADER_SECOND, second);
    cfg_valid      <= 1'b0;
    hdr_now_first  = first;
    hdr_now_second = second;
  endtask

  // builds one frame (or a scrap of noise) and pushes it byte by byte
  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] fb[$];
    logic [7:0] acc;
    int         cut;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 8)) fb.push_back(noise_byte());
    end else begin
      fb.push_back(hdr_now_first);
      fb.push_back(hdr_now_second);
      fb.push_back(8'($urandom));   // length byte, ignored by the block
      repeat (4 * WORD_COUNT) fb.push_back(content_byte());
      acc = '0;
      for (int i = 0; i < CRC_SPAN; i++) acc = sb.crc_update(acc, fb[i]);
      fb.push_back(acc);
      case (kind)
        FR_BAD_CRC: fb[CRC_POS] = fb[CRC_POS] ^ 8'($urandom_range(1, 255));
        FR_BAD_HDR: begin
          cut     = $urandom_range(0, 1);
          fb[cut] = fb[cut] ^ 8'($urandom_range(1, 255));
        end
        FR_LONG: begin
          // trailing filler lengthens the frame, at times far enough to saturate the byte count
          repeat ($urandom_range(1, 26)) begin
            acc = content_byte();
            if (acc == CHAR_LF) acc = 8'h0B;
            fb.push_back(acc);
          end
        end
        FR_SHORT: begin
          cut = $urandom_range(0, 43);
          while (fb.size() > cut) void'(fb.pop_back());
        end
        default: ;
      endcase
      fb.push_back(CHAR_CR);
      fb.push_back(CHAR_LF);
    end
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    int w;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        w               = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        w = draw_gap(rx_mode);
      end
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      sb.check_frame(out_status, {out_word9, out_word8, out_word7, out_word6, out_word5,
                                  out_word4, out_word3, out_word2, out_word1, out_word0});
      @(negedge clk);
    end
  end

  // main sequence
  initial begin
    int random_start;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset headers; extreme bytes then cr lf, header wrong at byte 0
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    // right header but far too short
    send_byte(HDR0_RST);
    send_byte(HDR1_RST);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    // bare cr lf, the cr itself is checked as the first header byte
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    // second header byte wrong on a short frame, header error must win
    send_byte(HDR0_RST);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    // lone lf does not close a frame, cr cr lf does
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);

    // headers equal to cr lf: a bare terminator now passes the header check
    set_headers(CHAR_CR, CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);

    // random frames under several header settings, extremes first
    random_start = bytes_sent;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       set_headers(8'h00, 8'hFF);
        1:       set_headers(8'hFF, 8'h00);
        2:       set_headers(8'($urandom), 8'($urandom));
        default: set_headers(HDR0_RST, HDR1_RST);
      endcase
      if (p == 0) begin
        // receiver stalls for a long stretch while tiny frames pour in back to back
        hold_off_cycles = HOLD_CYCLES;
        burst_active    = 1'b1;
        repeat (12) begin
          send_byte(hdr_now_first);
          send_byte(hdr_now_second);
          send_byte(CHAR_CR);
          send_byte(CHAR_LF);
        end
        burst_active = 1'b0;
      end
      while (bytes_sent - random_start < (p + 1) * RANDOM_BYTES / 4)
        send_frame(pick_kind());
      // close whatever partial frame noise left open
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/crc8fr_pkg.sv
hw/rtl/crc8fr_front.sv
hw/rtl/crc8fr_queue.sv
hw/rtl/crc8fr_back.sv
hw/rtl/crc8_checked_frame_receiver.sv
verif/tb_top.sv
